// ===== design/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants of the button debouncer and event detector.
// ----------------------------------------------------------------------------
package bde_pkg;

  // Width of the millisecond time base; all time differences wrap at this width.
  localparam int TIME_WIDTH = 32;

  localparam int DEBOUNCE_WIDTH  = 16;
  localparam int SHORT_MIN_WIDTH = 16;
  localparam int HOLD_WIDTH      = 32;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_MS  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_MIN_MS = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_MS      = 2'd2;

  // Register values after reset.
  localparam logic [DEBOUNCE_WIDTH-1:0]  DEBOUNCE_RESET  = 16'd15;
  localparam logic [SHORT_MIN_WIDTH-1:0] SHORT_MIN_RESET = 16'd50;
  localparam logic [HOLD_WIDTH-1:0]      HOLD_RESET      = 32'd3000;

  // One poll of the button pin.
  typedef struct packed {
    logic                  pin_level;
    logic [TIME_WIDTH-1:0] now_ms;
  } poll_t;

  // Result of one poll.
  typedef struct packed {
    logic stable_level;
    logic press_event;
    logic release_event;
    logic short_event;
    logic hold_event;
  } result_t;

endpackage

// ===== design/bde_input_stage.sv =====
// ----------------------------------------------------------------------------
// bde_input_stage
// Input register: captures one poll word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bde_input_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bde_pkg::poll_t poll_in,
  input  logic           advance,
  output logic           held_valid,
  output bde_pkg::poll_t held_poll
);
  import bde_pkg::*;

  logic accept;

  // A held word that cannot move on blocks the sender.
  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_poll <= poll_in;
    end
  end

endmodule

// ===== design/bde_core.sv =====
// ----------------------------------------------------------------------------
// bde_core
// Configuration registers, debounce and press state, and the event logic.
// ----------------------------------------------------------------------------
module bde_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [bde_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [bde_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  input  logic                                   advance,
  input  bde_pkg::poll_t                         poll,
  output bde_pkg::result_t                       result
);
  import bde_pkg::*;

  logic [DEBOUNCE_WIDTH-1:0]  debounce_ms;
  logic [SHORT_MIN_WIDTH-1:0] short_min_ms;
  logic [HOLD_WIDTH-1:0]      hold_ms;

  logic                  filtered_level;
  logic                  debouncing;
  logic [TIME_WIDTH-1:0] debounce_start;
  logic                  current_level;
  logic [TIME_WIDTH-1:0] press_start;
  logic                  hold_armed;

  logic                  filtered_level_next;
  logic                  debouncing_next;
  logic [TIME_WIDTH-1:0] debounce_start_next;
  logic                  current_level_next;
  logic [TIME_WIDTH-1:0] press_start_next;
  logic                  hold_armed_next;

  logic                  changed;
  logic                  pending;
  logic                  settle;
  logic [TIME_WIDTH-1:0] debounce_elapsed;
  logic [TIME_WIDTH-1:0] press_elapsed;
  logic                  rise;
  logic                  fall;
  logic                  hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms  <= DEBOUNCE_RESET;
      short_min_ms <= SHORT_MIN_RESET;
      hold_ms      <= HOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:  debounce_ms  <= cfg_data[DEBOUNCE_WIDTH-1:0];
        REG_SHORT_MIN_MS: short_min_ms <= cfg_data[SHORT_MIN_WIDTH-1:0];
        REG_HOLD_MS:      hold_ms      <= cfg_data[HOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The registered stable level doubles as the previous level for edge detection.
  always_comb begin
    changed             = poll.pin_level != filtered_level;
    filtered_level_next = poll.pin_level;
    pending             = debouncing || changed;
    debounce_start_next = changed ? poll.now_ms : debounce_start;
    debounce_elapsed    = changed ? '0 : poll.now_ms - debounce_start;
    settle              = pending && (debounce_elapsed >= TIME_WIDTH'(debounce_ms));
    debouncing_next     = pending && !settle;
    current_level_next  = settle ? filtered_level_next : current_level;

    rise = current_level_next && !current_level;
    fall = !current_level_next && current_level;

    press_elapsed    = poll.now_ms - press_start;
    press_start_next = rise ? poll.now_ms : press_start;

    // On the press poll itself the elapsed time is zero.
    if (rise) begin
      hold = hold_ms == '0;
    end else begin
      hold = hold_armed && !fall && (press_elapsed >= TIME_WIDTH'(hold_ms));
    end
    hold_armed_next = rise ? !hold : (hold_armed && !fall && !hold);

    result.stable_level  = current_level_next;
    result.press_event   = rise;
    result.release_event = fall;
    result.short_event   = fall && (press_elapsed >= TIME_WIDTH'(short_min_ms));
    result.hold_event    = hold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_level <= 1'b0;
      debouncing     <= 1'b0;
      debounce_start <= '0;
      current_level  <= 1'b0;
      press_start    <= '0;
      hold_armed     <= 1'b0;
    end else if (advance) begin
      filtered_level <= filtered_level_next;
      debouncing     <= debouncing_next;
      debounce_start <= debounce_start_next;
      current_level  <= current_level_next;
      press_start    <= press_start_next;
      hold_armed     <= hold_armed_next;
    end
  end

endmodule

// ===== design/bde_output_stage.sv =====
// ----------------------------------------------------------------------------
// bde_output_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module bde_output_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bde_pkg::result_t result_in,
  output logic             out_valid,
  input  logic             out_stall,
  output bde_pkg::result_t result_out
);
  import bde_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== design/button_debounce_event_detector.sv =====
// ----------------------------------------------------------------------------
// button_debounce_event_detector
// Push-button debouncer with press, release, short-press and hold events.
// ----------------------------------------------------------------------------
// Usage: each input word is one poll of the button: the raw pin level and the
// current millisecond tick. Every poll yields exactly one result word with the
// debounced level and the press, release, short and hold event flags.
// Both channels use valid and stall; a word moves at a clock edge where valid
// is high and stall is low.
// A poll taken into the input register is evaluated against the block state
// and lands in the result register when it is free or being emptied; out_valid
// then rises. Throughput is one poll per clock cycle while the receiver does
// not stall, set by the single compare and subtract pass between the registers.
// When the receiver stalls, the result word holds, the input register still
// takes one more poll, and only then is in_stall raised.
// Reset (synchronous, active high) empties both registers, loads the timing
// registers with 15 ms debounce, 50 ms short-press minimum and 3000 ms hold,
// and clears the debounce and press state to the released level.
// Configuration writes go through cfg_write, cfg_index and cfg_data and take
// effect at once; they are meant to be made while no poll is in flight.
// ----------------------------------------------------------------------------
module button_debounce_event_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bde_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bde_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                pin_level,
  input  logic [bde_pkg::TIME_WIDTH-1:0]      now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                stable_level,
  output logic                                press_event,
  output logic                                release_event,
  output logic                                short_event,
  output logic                                hold_event
);
  import bde_pkg::*;

  poll_t   poll_in;
  poll_t   held_poll;
  logic    held_valid;
  logic    advance;
  result_t core_result;
  result_t result_out;

  assign poll_in.pin_level = pin_level;
  assign poll_in.now_ms    = now_ms;

  // The held poll is evaluated whenever the result register is free or
  // is being emptied in this cycle.
  assign advance = held_valid && (!out_valid || !out_stall);

  bde_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .poll_in    (poll_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_poll  (held_poll)
  );

  bde_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .poll      (held_poll),
    .result    (core_result)
  );

  bde_output_stage u_output (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (core_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (result_out)
  );

  assign stable_level  = result_out.stable_level;
  assign press_event   = result_out.press_event;
  assign release_event = result_out.release_event;
  assign short_event   = result_out.short_event;
  assign hold_event    = result_out.hold_event;

endmodule

// ===== design/bde_checker.sv =====
// ----------------------------------------------------------------------------
// bde_checker
// Port-level checks of the button debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module bde_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic stable_level,
  input logic press_event,
  input logic release_event,
  input logic short_event,
  input logic hold_event
);

  // A stalled result word stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // The input side only backs up when the output side is full and stalled.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back pressure");

  // Edge flags agree with the debounced level they produce.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && press_event |-> stable_level && !release_event)
    else $error("press event without a high stable level");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && release_event |-> !stable_level && !hold_event)
    else $error("release event inconsistent with level or hold");

  // A short press is only reported on a release.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && short_event |-> release_event)
    else $error("short press without release");

endmodule

bind button_debounce_event_detector bde_checker u_bde_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .stable_level  (stable_level),
  .press_event   (press_event),
  .release_event (release_event),
  .short_event   (short_event),
  .hold_event    (hold_event)
);

// ===== dv/tb_button_debounce_event_detector.sv =====
// ----------------------------------------------------------------------------
// tb_button_debounce_event_detector
// Self-checking testbench for the push-button debouncer and event detector.
// ----------------------------------------------------------------------------
// Polls are sent as words of pin level and millisecond tick. A behavioral
// model inside the testbench predicts the debounced level and the press,
// release, short and hold flags of every accepted poll. A monitor compares
// each result word with the oldest prediction. Both sides idle at random,
// the receiver also holds off for a long stretch, and the timing registers
// are changed between phases, including zero and full-scale values.
// ----------------------------------------------------------------------------
module tb_button_debounce_event_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import bde_pkg::*;

  // Index past the last timing register; writes to it must change nothing.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  localparam int unsigned MAX_GAP     = 17;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_POLLS = 175;

  // Every input starts at a known value; reset is high from time zero.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       pin_level = 1'b0;
  logic [TIME_WIDTH-1:0]      now_ms = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       stable_level;
  logic                       press_event;
  logic                       release_event;
  logic                       short_event;
  logic                       hold_event;

  button_debounce_event_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pin_level     (pin_level),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stable_level  (stable_level),
    .press_event   (press_event),
    .release_event (release_event),
    .short_event   (short_event),
    .hold_event    (hold_event)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result words predicted for accepted polls, oldest first.
  result_t predicted_events[$];

  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned poll_count = 0;
  int unsigned cycle_count = 0;

  // Idling controls: when a flag is low that side draws no random idle gaps.
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int unsigned hold_off_request = 0;
  bit          word_taken = 1'b0;
  int unsigned stall_left = 0;

  // Running millisecond tick of the random traffic.
  logic [TIME_WIDTH-1:0] tick_ms = '0;

  // Model copy of the timing registers, held at the time width.
  logic [TIME_WIDTH-1:0] m_debounce_ms = TIME_WIDTH'(DEBOUNCE_RESET);
  logic [TIME_WIDTH-1:0] m_short_ms    = TIME_WIDTH'(SHORT_MIN_RESET);
  logic [TIME_WIDTH-1:0] m_hold_ms     = TIME_WIDTH'(HOLD_RESET);

  // Model copy of the debounce and press state; all of it clears on reset.
  logic                  m_filtered   = 1'b0;
  logic                  m_debouncing = 1'b0;
  logic [TIME_WIDTH-1:0] m_change_ms  = '0;
  logic                  m_stable     = 1'b0;
  logic                  m_last       = 1'b0;
  logic [TIME_WIDTH-1:0] m_press_ms   = '0;
  logic                  m_hold_armed = 1'b0;

  // Advances the model by one poll and returns the result word it implies.
  // Time differences are taken in TIME_WIDTH bits so that they wrap.
  function automatic result_t debounce_poll(input logic pin,
                                            input logic [TIME_WIDTH-1:0] t);
    result_t               r;
    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] held_for;
    r = '0;
    // Any change of the raw level restarts the debounce window.
    if (pin != m_filtered) begin
      m_debouncing = 1'b1;
      m_filtered   = pin;
      m_change_ms  = t;
    end
    since_change = t - m_change_ms;
    if (m_debouncing && since_change >= m_debounce_ms) begin
      m_stable     = m_filtered;
      m_debouncing = 1'b0;
    end
    if (m_stable != m_last) begin
      m_last = m_stable;
      if (m_stable) begin
        r.press_event = 1'b1;
        m_press_ms    = t;
        m_hold_armed  = 1'b1;
      end else begin
        held_for = t - m_press_ms;
        if (held_for >= m_short_ms) begin
          r.short_event = 1'b1;
        end
        r.release_event = 1'b1;
        m_hold_armed    = 1'b0;
      end
    end
    // The hold flag fires once per press; the press edge itself may fire it.
    held_for = t - m_press_ms;
    if (m_hold_armed && held_for >= m_hold_ms) begin
      m_hold_armed = 1'b0;
      r.hold_event = 1'b1;
    end
    r.stable_level = m_stable;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch on %s at result %0d: expected %b, got %b",
               what, checked_count, want, got);
    end
  endtask

  // Run limit, far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result monitor: a word moves at a rising edge with valid high and stall
  // low. It is checked field by field against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      word_taken = 1'b1;
      if (predicted_events.size() == 0) begin
        report_mismatch("unexpected word", 1'b0, 1'b1);
      end else begin
        want = predicted_events.pop_front();
        if (stable_level !== want.stable_level)
          report_mismatch("stable_level", want.stable_level, stable_level);
        if (press_event !== want.press_event)
          report_mismatch("press_event", want.press_event, press_event);
        if (release_event !== want.release_event)
          report_mismatch("release_event", want.release_event, release_event);
        if (short_event !== want.short_event)
          report_mismatch("short_event", want.short_event, short_event);
        if (hold_event !== want.hold_event)
          report_mismatch("hold_event", want.hold_event, hold_event);
      end
      checked_count++;
    end
  end

  // Receiver stall: after each taken word it draws a stall length. A long
  // hold-off request from a test overrides the draw and is counted down here,
  // so that the sender keeps offering polls while the block fills up.
  always @(negedge clk) begin
    if (hold_off_request != 0) begin
      stall_left       = hold_off_request;
      hold_off_request = 0;
    end else if (word_taken) begin
      stall_left = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    end
    word_taken = 1'b0;
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one poll after a random gap and waits for the handshake. Valid is
  // left high after acceptance so that back-to-back polls keep it high.
  task automatic send_poll(input logic pin, input logic [TIME_WIDTH-1:0] t);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    now_ms    <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted_events.push_back(debounce_poll(pin, t));
    poll_count++;
  endtask

  // Sends one poll a given number of milliseconds after the previous one.
  task automatic poll(input logic pin, input logic [TIME_WIDTH-1:0] step);
    tick_ms = tick_ms + step;
    send_poll(pin, tick_ms);
  endtask

  // Drops valid and waits until every predicted word has been taken, then
  // lets the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_events.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Register writes are made only while the block is idle.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_DEBOUNCE_MS:  m_debounce_ms = TIME_WIDTH'(val[DEBOUNCE_WIDTH-1:0]);
      REG_SHORT_MIN_MS: m_short_ms    = TIME_WIDTH'(val[SHORT_MIN_WIDTH-1:0]);
      REG_HOLD_MS:      m_hold_ms     = TIME_WIDTH'(val[HOLD_WIDTH-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CFG_DATA_WIDTH-1:0] debounce,
                            input logic [CFG_DATA_WIDTH-1:0] short_min,
                            input logic [CFG_DATA_WIDTH-1:0] hold);
    wait_idle();
    write_reg(REG_DEBOUNCE_MS, debounce);
    write_reg(REG_SHORT_MIN_MS, short_min);
    write_reg(REG_HOLD_MS, hold);
  endtask

  // One press and release with contact bounce on both edges. Steps are
  // multiplied by scale so that long debounce settings still settle.
  task automatic press_sequence(input int unsigned scale);
    logic lvl;
    lvl = 1'b1;
    repeat ($urandom_range(0, 4)) begin
      poll(lvl, $urandom_range(0, 3) * scale);
      lvl = ~lvl;
    end
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 15))
      poll(1'b1, $urandom_range(0, 12) * scale);
    lvl = 1'b0;
    repeat ($urandom_range(0, 4)) begin
      poll(lvl, $urandom_range(0, 3) * scale);
      lvl = ~lvl;
    end
    repeat ($urandom_range(1, 15)) poll(1'b0, $urandom_range(0, 12) * scale);
  endtask

  // Reset timing: bounce that is too short to settle, a settled press, one
  // hold event that does not repeat, a long release with a short-press flag,
  // then a press too brief for the short-press flag.
  task automatic test_default_timing();
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd5);
    send_poll(1'b0, 32'd8);
    send_poll(1'b1, 32'd10);
    send_poll(1'b1, 32'd24);
    send_poll(1'b1, 32'd25);
    send_poll(1'b1, 32'd60);
    send_poll(1'b1, 32'd3024);
    send_poll(1'b1, 32'd3025);
    send_poll(1'b1, 32'd3100);
    send_poll(1'b0, 32'd3101);
    send_poll(1'b0, 32'd3116);
    send_poll(1'b1, 32'd4000);
    send_poll(1'b1, 32'd4015);
    send_poll(1'b0, 32'd4020);
    send_poll(1'b0, 32'd4035);
    send_poll(1'b0, 32'd4100);
  endtask

  // Zero debounce and hold: a change settles in the same poll and the press
  // fires hold at once. Timestamps also run backward, which simply wraps.
  // A write to the spare index must leave all timing untouched.
  task automatic test_zero_timing();
    set_timing(32'd0, 32'd0, 32'd0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'd5000);
    send_poll(1'b1, 32'd4990);
    send_poll(1'b0, 32'd4980);
    send_poll(1'b1, 32'd100);
    send_poll(1'b0, 32'd100);
    send_poll(1'b0, 32'd99);
  endtask

  // Full-scale registers with the tick wrapping past zero. The hold fires
  // only when the wrapped press time reaches all ones.
  task automatic test_full_scale_timing();
    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'hFFFF_FFF0);
    send_poll(1'b1, 32'h0000_FFEE);
    send_poll(1'b1, 32'h0000_FFEF);
    send_poll(1'b1, 32'h7FFF_FFFF);
    send_poll(1'b1, 32'h0000_FFED);
    send_poll(1'b1, 32'h0000_FFEE);
    send_poll(1'b1, 32'h0000_FFEF);
    send_poll(1'b0, 32'h0001_0000);
    send_poll(1'b0, 32'h0001_FFFE);
    send_poll(1'b0, 32'h0001_FFFF);
    tick_ms = 32'h0002_0000;
  endtask

  // The receiver holds off while the sender streams polls without gaps, so
  // that the result and input registers fill and in_stall rises. Then the
  // sender pauses until every result has come before it resumes.
  task automatic test_backpressure();
    set_timing(32'd2, 32'd5, 32'd10);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_off_request = LONG_HOLD;
    repeat (3) press_sequence(1);
    wait_idle();
    rx_gaps = 1'b1;
    repeat (2) press_sequence(1);
    tx_gaps = 1'b1;
  endtask

  // Random traffic in phases with different timing and idling. Most of it is
  // well-formed press sequences; the rest is noise with arbitrary ticks.
  task automatic test_random_traffic();
    int unsigned scale;
    int unsigned target;
    logic [CFG_DATA_WIDTH-1:0] debounce;
    logic [CFG_DATA_WIDTH-1:0] short_min;
    logic [CFG_DATA_WIDTH-1:0] hold;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      debounce  = (phase == 2) ? 32'd0 : $urandom_range(1, 20);
      short_min = (phase == 3) ? 32'd0 : $urandom_range(0, 80);
      hold      = (phase == 4) ? 32'd0 :
                  (phase == 5) ? 32'hFFFF_FFFF : $urandom_range(1, 400);
      scale     = 1;
      if (phase == PHASES - 1) begin
        debounce  = 32'h0000_FFFF;
        short_min = 32'h0000_FFFF;
        hold      = $urandom();
        scale     = 8000;
      end
      set_timing(debounce, short_min, hold);
      // Four idling modes: both sides, sender only, receiver only, neither.
      tx_gaps = (phase % 4 == 0) || (phase % 4 == 1);
      rx_gaps = (phase % 4 == 0) || (phase % 4 == 2);
      if (phase == 6) begin
        tick_ms = 32'hFFFF_FE00;
      end
      target = poll_count + PHASE_POLLS;
      while (poll_count < target) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            tick_ms = $urandom();
            send_poll(1'($urandom_range(0, 1)), tick_ms);
          end
        end else begin
          press_sequence(scale);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_default_timing();
    test_zero_timing();
    test_full_scale_timing();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== button_debounce_event_detector.f =====
design/bde_pkg.sv
design/bde_input_stage.sv
design/bde_core.sv
design/bde_output_stage.sv
design/button_debounce_event_detector.sv
design/bde_checker.sv
dv/tb_button_debounce_event_detector.sv
